// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL of the UYVY to semi-planar core.
// Each macro expands to one labeled concurrent assertion on the rising clock
// edge, disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/core/uyvy_sp_pkg.sv =====
// ----------------------------------------------------------------------------
// uyvy_sp_pkg
// Shared types and constants for the UYVY to semi-planar 4:2:0 write core.
// ----------------------------------------------------------------------------
package uyvy_sp_pkg;

  localparam int CFG_W          = 12;
  localparam int ADDR_W         = 23;
  localparam int LUMA_BASE_W    = 22;
  localparam int BYTE_W         = 8;
  localparam int PROD_W         = 2 * CFG_W;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // Register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] u_byte;
    logic [BYTE_W-1:0] luma_first;
    logic [BYTE_W-1:0] v_byte;
    logic [BYTE_W-1:0] luma_second;
  } in_item_t;

  typedef struct packed {
    logic              to_chroma_plane;
    logic [ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0] byte_at_address;
    logic [BYTE_W-1:0] byte_after;
    logic              last_of_item;
    logic              frame_done;
  } out_item_t;

  // One macropixel that produces writes, as handed to the emitter
  typedef struct packed {
    logic              has_chroma;
    logic              frame_done;
    logic [ADDR_W-1:0] luma_addr;
    logic [ADDR_W-1:0] chroma_addr;
    logic [BYTE_W-1:0] y0;
    logic [BYTE_W-1:0] y1;
    logic [BYTE_W-1:0] v;
  } item_ctl_t;

  // Line store access for one transaction
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [BYTE_W-1:0] wr_data;
  } store_req_t;

  // Column counter width: enough to index MAX_WIDTH/2 macropixels, at least 1
  function automatic int col_bits(int max_width);
    int half;
    half = max_width >> 1;
    return (half > 1) ? $clog2(half) : 1;
  endfunction

endpackage

// ===== rtl/core/uyvy_sp_line_store.sv =====
// ----------------------------------------------------------------------------
// uyvy_sp_line_store
// Single-port chroma line store: keeps the U byte of each even-row
// macropixel for the odd row below. Read data is registered.
// ----------------------------------------------------------------------------
module uyvy_sp_line_store
  import uyvy_sp_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  store_req_t                     req,
  input  logic [col_bits(MAX_WIDTH)-1:0] addr,
  output logic [BYTE_W-1:0]              rd_data
);

  localparam int AW    = col_bits(MAX_WIDTH);
  localparam int DEPTH = 1 << AW;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= req.wr_data;
    end
    // hold the last read while the emitter waits on the output
    if (req.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/uyvy_sp_addr_gen.sv =====
// ----------------------------------------------------------------------------
// uyvy_sp_addr_gen
// Raster position counters and plane address generation. Issues line store
// accesses and hands each writing macropixel to the emitter.
// ----------------------------------------------------------------------------
module uyvy_sp_addr_gen
  import uyvy_sp_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [CFG_W-1:0]               frame_width,
  input  logic [CFG_W-1:0]               frame_height,
  input  logic                           accept,
  input  in_item_t                       in_item,
  output logic                           item_valid,
  output item_ctl_t                      item,
  output store_req_t                     store_req,
  output logic [col_bits(MAX_WIDTH)-1:0] store_addr
);

  localparam int CW    = col_bits(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CMP_W = 16;

  localparam logic [CMP_W-1:0] MAXW = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] MAXH = CMP_W'(MAX_HEIGHT);

  logic [CW-1:0]          col_r, col_nxt;
  logic [RW-1:0]          row_r, row_nxt;
  logic [LUMA_BASE_W-1:0] lbase_r, lbase_nxt;
  logic [ADDR_W-1:0]      cbase_r, cbase_nxt;
  logic [PROD_W-1:0]      prod;

  logic [CFG_W-1:0] w_clamp, w_even, w_eff;
  logic [CFG_W-1:0] h_clamp, h_eff, cols, pair_rows;
  logic [CW:0]      col_inc;
  logic [RW:0]      row_inc;
  logic             row_end, frame_end, in_pair, odd, pair_done;
  logic [ADDR_W-1:0] col2;

  always_comb begin
    w_clamp = (CMP_W'(frame_width) > MAXW) ? MAXW[CFG_W-1:0] : frame_width;
    w_even  = {w_clamp[CFG_W-1:1], 1'b0};
    w_eff   = (w_even < CFG_W'(2)) ? CFG_W'(2) : w_even;
    h_clamp = (CMP_W'(frame_height) > MAXH) ? MAXH[CFG_W-1:0] : frame_height;
    h_eff   = (h_clamp < CFG_W'(2)) ? CFG_W'(2) : h_clamp;

    // chroma plane offset, taken from the current frame size
    prod    = PROD_W'(w_eff) * PROD_W'(h_eff);

    cols      = {1'b0, w_eff[CFG_W-1:1]};
    pair_rows = {h_eff[CFG_W-1:1], 1'b0};

    col_inc   = {1'b0, col_r} + (CW+1)'(1);
    row_inc   = {1'b0, row_r} + (RW+1)'(1);
    row_end   = CMP_W'(col_inc) >= CMP_W'(cols);
    frame_end = row_end && (CMP_W'(row_inc) >= CMP_W'(h_eff));
    pair_done = row_end && (CMP_W'(row_inc) >= CMP_W'(pair_rows));
    in_pair   = CMP_W'(row_r) < CMP_W'(pair_rows);
    odd       = row_r[0];
    col2      = ADDR_W'({col_r, 1'b0});
  end

  // next position
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    lbase_nxt = lbase_r;
    cbase_nxt = cbase_r;
    if (accept) begin
      if (frame_end) begin
        col_nxt   = '0;
        row_nxt   = '0;
        lbase_nxt = '0;
        cbase_nxt = '0;
      end else if (row_end) begin
        col_nxt   = '0;
        row_nxt   = row_inc[RW-1:0];
        lbase_nxt = lbase_r + LUMA_BASE_W'(w_eff);
        if (odd) begin
          cbase_nxt = cbase_r + ADDR_W'(w_eff);
        end
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      lbase_r <= '0;
      cbase_r <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      lbase_r <= lbase_nxt;
      cbase_r <= cbase_nxt;
    end
  end

  always_comb begin
    item_valid        = accept && in_pair;
    item.has_chroma   = odd;
    item.frame_done   = odd && pair_done;
    item.luma_addr    = ADDR_W'(lbase_r) + col2;
    item.chroma_addr  = prod[ADDR_W-1:0] + cbase_r + col2;
    item.y0           = in_item.luma_first;
    item.y1           = in_item.luma_second;
    item.v            = in_item.v_byte;

    store_req.wr_en   = accept && in_pair && !odd;
    store_req.rd_en   = accept && in_pair && odd;
    store_req.wr_data = in_item.u_byte;
    store_addr        = col_r;
  end

endmodule

// ===== rtl/core/uyvy_sp_emit.sv =====
// ----------------------------------------------------------------------------
// uyvy_sp_emit
// Output sequencer: holds one macropixel and issues its luma write, then its
// chroma write on odd rows, through a registered output stage.
// ----------------------------------------------------------------------------
module uyvy_sp_emit
  import uyvy_sp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_load,
  input  item_ctl_t         item,
  input  logic [BYTE_W-1:0] rd_data,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  `include "assert_macros.svh"

  logic      b_valid_r, b_valid_nxt;
  logic      b_phase_r, b_phase_nxt;
  item_ctl_t b_item_r;
  logic      out_valid_r;
  out_item_t out_data_r, sel;
  logic      o_load, emit, b_done;

  always_comb begin
    o_load    = !out_valid_r || out_ready;
    emit      = b_valid_r && o_load;
    b_done    = emit && (b_phase_r || !b_item_r.has_chroma);
    slot_free = !b_valid_r || b_done;

    b_valid_nxt = b_valid_r;
    b_phase_nxt = b_phase_r;
    if (item_load) begin
      b_valid_nxt = 1'b1;
      b_phase_nxt = 1'b0;
    end else if (b_done) begin
      b_valid_nxt = 1'b0;
    end else if (emit) begin
      // luma sent, chroma next
      b_phase_nxt = 1'b1;
    end

    if (b_phase_r) begin
      sel.to_chroma_plane = 1'b1;
      sel.write_address   = b_item_r.chroma_addr;
      sel.byte_at_address = b_item_r.v;
      sel.byte_after      = rd_data;
      sel.last_of_item    = 1'b1;
      sel.frame_done      = b_item_r.frame_done;
    end else begin
      sel.to_chroma_plane = 1'b0;
      sel.write_address   = b_item_r.luma_addr;
      sel.byte_at_address = b_item_r.y0;
      sel.byte_after      = b_item_r.y1;
      sel.last_of_item    = !b_item_r.has_chroma;
      sel.frame_done      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      b_phase_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      b_phase_r <= b_phase_nxt;
      if (o_load) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      b_item_r <= item;
    end
    if (emit) begin
      out_data_r <= sel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_load_busy, clk, rst_n, item_load && !slot_free, "item loaded into busy slot")
  `ASSERT_AT(a_phase_chroma, clk, rst_n, b_valid_r && b_phase_r |-> b_item_r.has_chroma, "chroma phase on luma-only item")
  `ASSERT_AT(a_chroma_follows, clk, rst_n, emit && !b_phase_r && b_item_r.has_chroma |=> b_valid_r && b_phase_r, "chroma write lost after luma")

endmodule

// ===== rtl/core/uyvy_to_semiplanar_420_core.sv =====
// Takes one UYVY macropixel per input transaction in raster order and issues
// two-byte writes for a semi-planar 4:2:0 buffer: a luma write for every
// macropixel of the frame's paired rows, and on odd rows a chroma write (V of
// the odd row, then U kept from the even row) right after it. Even rows
// accept one macropixel per cycle unless the result port stalls; odd rows
// wait for both writes, which share the single result port and are held in
// the item slot, then the output register. U bytes live in a single-port
// line store of 2**ceil(log2(MAX_WIDTH/2)) bytes with no clearing pass after
// reset: an odd row only reads entries that the even row above it wrote. A
// trailing unpaired row is taken with no writes. The user must write width
// and height through the configuration port only while no transaction is
// in flight (unenforced); they apply from the next accepted transaction.
// ----------------------------------------------------------------------------
// uyvy_to_semiplanar_420_core
// Top level: configuration registers, address generator, line store and
// output sequencer.
// ----------------------------------------------------------------------------
module uyvy_to_semiplanar_420_core
  import uyvy_sp_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int CW = col_bits(MAX_WIDTH);

  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic             in_accept;
  logic             item_valid;
  item_ctl_t        item;
  store_req_t       store_req;
  logic [CW-1:0]    store_addr;
  logic [BYTE_W-1:0] rd_data;
  logic             slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
      endcase
    end
  end

  assign in_ready  = slot_free;
  assign in_accept = in_valid && in_ready;

  uyvy_sp_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr_gen (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .accept       (in_accept),
    .in_item      (in_data),
    .item_valid   (item_valid),
    .item         (item),
    .store_req    (store_req),
    .store_addr   (store_addr)
  );

  uyvy_sp_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .req     (store_req),
    .addr    (store_addr),
    .rd_data (rd_data)
  );

  uyvy_sp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_load (item_valid),
    .item      (item),
    .rd_data   (rd_data),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb_uyvy_to_semiplanar_420_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uyvy_to_semiplanar_420_core
// Drives UYVY macropixels into the semi-planar 4:2:0 write core and checks
// each luma and chroma write against a cycle-free write predictor. Frame size
// changes between phases, only with the core idle and at the start of a row.
// Sender gaps, receiver stalls and a long receiver hold-off vary by phase.
// ----------------------------------------------------------------------------
module tb_uyvy_to_semiplanar_420_core;
  import uyvy_sp_pkg::*;

  localparam int unsigned MAX_W           = MAX_WIDTH_DEF;
  localparam int unsigned MAX_H           = MAX_HEIGHT_DEF;
  localparam int          DRAIN_CYCLES    = 16;
  localparam int          HOLD_OFF_CYCLES = 600;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  cfg_reg_t         cfg_addr = REG_FRAME_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;

  uyvy_to_semiplanar_420_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus and expectation stores
  in_item_t  pixel_queue[$];
  out_item_t expected_writes[$];
  int        in_sent = 0;
  int        in_taken = 0;
  int        mismatch_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off_asked = 0;
  int        hold_off_served = 0;
  int        hold_off_left = 0;

  // Predictor copy of the frame walker
  logic [CFG_W-1:0] cur_width = WIDTH_RESET;
  logic [CFG_W-1:0] cur_height = HEIGHT_RESET;
  int unsigned      pix_col = 0;
  int unsigned      pix_row = 0;
  int unsigned      luma_base = 0;
  int unsigned      chroma_base = 0;
  logic [7:0]       u_line [0:MAX_W/2];

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cur_width;
    if (w > MAX_W) w = MAX_W;
    w = w & 32'hFFFF_FFFE;
    if (w < 2) w = 2;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = cur_height;
    if (h > MAX_H) h = MAX_H;
    if (h < 2) h = 2;
    return h;
  endfunction

  task automatic predict_writes(input in_item_t px);
    int unsigned w, h, cols, pair_rows, addr;
    bit          row_end, frame_end, odd_row, last_pair;
    out_item_t   wr;
    w         = eff_width();
    h         = eff_height();
    cols      = w / 2;
    pair_rows = h & 32'hFFFF_FFFE;
    row_end   = (pix_col + 1) >= cols;
    frame_end = row_end && (pix_row + 1) >= h;
    odd_row   = pix_row[0];
    if (pix_row < pair_rows) begin
      addr                = luma_base + 2 * pix_col;
      wr.to_chroma_plane  = 1'b0;
      wr.write_address    = addr[ADDR_W-1:0];
      wr.byte_at_address  = px.luma_first;
      wr.byte_after       = px.luma_second;
      wr.last_of_item     = !odd_row;
      wr.frame_done       = 1'b0;
      expected_writes.push_back(wr);
      if (!odd_row) begin
        u_line[pix_col] = px.u_byte;
      end else begin
        last_pair          = row_end && (pix_row + 1) >= pair_rows;
        addr               = w * h + chroma_base + 2 * pix_col;
        wr.to_chroma_plane = 1'b1;
        wr.write_address   = addr[ADDR_W-1:0];
        wr.byte_at_address = px.v_byte;
        wr.byte_after      = u_line[pix_col];
        wr.last_of_item    = 1'b1;
        wr.frame_done      = last_pair;
        expected_writes.push_back(wr);
      end
    end
    if (frame_end) begin
      pix_col     = 0;
      pix_row     = 0;
      luma_base   = 0;
      chroma_base = 0;
    end else if (row_end) begin
      pix_col   = 0;
      luma_base = (luma_base + w) & 32'h003F_FFFF;
      if (odd_row) chroma_base = (chroma_base + w) & 32'h007F_FFFF;
      pix_row   = (pix_row + 1) & 32'h0000_07FF;
    end else begin
      pix_col = (pix_col + 1) & 32'h0000_03FF;
    end
  endtask

  task automatic check_write(input out_item_t got);
    out_item_t exp;
    bit        bad;
    if (expected_writes.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected write: chroma=%0d addr=%h b0=%h b1=%h last=%0d done=%0d",
                 got.to_chroma_plane, got.write_address, got.byte_at_address,
                 got.byte_after, got.last_of_item, got.frame_done);
    end else begin
      exp = expected_writes.pop_front();
      bad = (got.to_chroma_plane !== exp.to_chroma_plane) ||
            (got.write_address   !== exp.write_address)   ||
            (got.byte_at_address !== exp.byte_at_address) ||
            (got.byte_after      !== exp.byte_after)      ||
            (got.last_of_item    !== exp.last_of_item)    ||
            (got.frame_done      !== exp.frame_done);
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("write mismatch: exp chroma=%0d addr=%h b0=%h b1=%h last=%0d done=%0d",
                   exp.to_chroma_plane, exp.write_address, exp.byte_at_address,
                   exp.byte_after, exp.last_of_item, exp.frame_done,
                   " | got chroma=%0d addr=%h b0=%h b1=%h last=%0d done=%0d",
                   got.to_chroma_plane, got.write_address, got.byte_at_address,
                   got.byte_after, got.last_of_item, got.frame_done);
      end
    end
  endtask

  // Sample both channels on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_write(out_data);
      if (in_valid && in_ready) begin
        predict_writes(in_data);
        in_taken <= in_taken + 1;
      end
    end
  end

  // Input driver: hold until accepted, then offer the next pixel or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_sent != in_taken) begin
      // hold the pending transaction
    end else if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_data  <= pixel_queue.pop_front();
      in_valid <= 1'b1;
      in_sent  <= in_sent + 1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready     <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_served != hold_off_asked) begin
      hold_off_served <= hold_off_asked;
      hold_off_left   <= HOLD_OFF_CYCLES;
      out_ready       <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic in_item_t make_pixel(logic [7:0] u, logic [7:0] y0,
                                          logic [7:0] v, logic [7:0] y1);
    in_item_t px;
    px.u_byte      = u;
    px.luma_first  = y0;
    px.v_byte      = v;
    px.luma_second = y1;
    return px;
  endfunction

  task automatic push_pixels(input int n);
    for (int i = 0; i < n; i++)
      pixel_queue.push_back(make_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte()));
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() != 0 || in_sent != in_taken || expected_writes.size() != 0)
      @(posedge clk);
    // trailing rows give no writes, so let the core settle anyway
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cur_width = val;
    else cur_height = val;
  endtask

  // Advance to the start of an even row, so that the next odd row only reads
  // line store entries written under the same width
  task automatic finish_to_even_row();
    int unsigned cols, n;
    cols = eff_width() / 2;
    n    = cols - pix_col;
    if (!pix_row[0] && !((pix_row + 1) >= eff_height())) n += cols;
    push_pixels(n);
    wait_idle();
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 79; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 79; end
      default:       begin send_idle_pct = 6;  recv_stall_pct = 6;  end
    endcase
  endtask

  initial begin
    logic [CFG_W-1:0] w_val, h_val;
    int               pick;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // Odd width rounds down, odd height leaves a trailing row with no writes
    write_reg(REG_FRAME_WIDTH, 12'd5);
    write_reg(REG_FRAME_HEIGHT, 12'd3);
    pixel_queue.push_back(make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
    pixel_queue.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    pixel_queue.push_back(make_pixel(8'h5A, 8'hA5, 8'hFF, 8'h00));
    pixel_queue.push_back(make_pixel(8'h00, 8'hFF, 8'h00, 8'hFF));
    pixel_queue.push_back(make_pixel(8'h12, 8'h34, 8'h56, 8'h78));
    pixel_queue.push_back(make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55));
    wait_idle();

    // Sizes below the minimum clamp to two
    write_reg(REG_FRAME_WIDTH, 12'd0);
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    pixel_queue.push_back(make_pixel(8'h81, 8'h7E, 8'h01, 8'hFE));
    pixel_queue.push_back(make_pixel(8'hC3, 8'h3C, 8'h99, 8'h66));
    wait_idle();

    // Shrink the height mid-frame below the current row
    write_reg(REG_FRAME_WIDTH, 12'd8);
    write_reg(REG_FRAME_HEIGHT, 12'd8);
    push_pixels(8);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 12'd2);
    finish_to_even_row();

    // Widest row, then narrow the odd row and drop the rest of the frame
    write_reg(REG_FRAME_WIDTH, 12'hFFF);
    write_reg(REG_FRAME_HEIGHT, 12'hFFF);
    push_pixels(MAX_W / 2);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 12'd6);
    push_pixels(3);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 12'd2);
    finish_to_even_row();

    for (int p = 0; p < 8; p++) begin
      set_idling(idle_mode_t'(p % 4));
      pick  = $urandom_range(9);
      w_val = (pick == 0) ? 12'($urandom_range(3)) : 12'($urandom_range(4, 48));
      pick  = $urandom_range(9);
      if (pick == 0) h_val = 12'hFFF;
      else if (pick == 1) h_val = 12'($urandom_range(3));
      else h_val = 12'($urandom_range(4, 12));
      write_reg(REG_FRAME_WIDTH, w_val);
      write_reg(REG_FRAME_HEIGHT, h_val);
      if (p == 4) hold_off_asked++;
      push_pixels($urandom_range(55, 95));
      finish_to_even_row();
    end

    wait_idle();
    if (mismatch_count == 0 && expected_writes.size() == 0) begin
      $display("uyvy_to_semiplanar_420_core: match");
    end else begin
      $display("uyvy_to_semiplanar_420_core: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("uyvy_to_semiplanar_420_core: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/uyvy_sp_pkg.sv
rtl/core/uyvy_sp_line_store.sv
rtl/core/uyvy_sp_addr_gen.sv
rtl/core/uyvy_sp_emit.sv
rtl/core/uyvy_to_semiplanar_420_core.sv
tb/tb_uyvy_to_semiplanar_420_core.sv
